[hw/rtl/ibra_pkg.sv]
// Shared types and constants for the interval buffer reuse allocator.
package ibra_pkg;

    localparam int MAX_BUFFERS = 64;
    localparam int TIME_BITS   = 16;
    localparam int SIZE_W      = 32;
    localparam int OWNER_W     = 6;
    localparam int IDX_W       = $clog2(MAX_BUFFERS);
    localparam int CNT_W       = $clog2(MAX_BUFFERS + 1);

    typedef logic [TIME_BITS-1:0] time_t;

    typedef struct packed {
        logic                first_of_set;
        logic [15:0]         start_time;
        logic [15:0]         end_time;
        logic [SIZE_W-1:0]   buffer_size;
        logic                size_known;
        logic                is_external;
    } in_item_t;

    typedef struct packed {
        logic [OWNER_W-1:0]  memory_owner;
        logic                reused;
        logic                overflow;
    } out_item_t;

    typedef struct packed {
        time_t               end_t;
        logic [OWNER_W-1:0]  owner;
        logic [SIZE_W-1:0]   size;
    } live_row_t;

    typedef struct packed {
        logic [OWNER_W-1:0]  owner;
        logic [SIZE_W-1:0]   size;
    } free_row_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REL_SCAN,
        ST_REL_DRAIN,
        ST_REL_DECIDE,
        ST_FIT_INIT,
        ST_FIT_RD,
        ST_FIT_CMP,
        ST_SHIFT_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_COMMIT,
        ST_DONE
    } ctl_state_t;

    typedef struct packed {
        logic load;
        logic set_ovf;
        logic set_unknown;
        logic scan_init;
        logic scan_step;
        logic rel_push;
        logic fit_init;
        logic fit_rd;
        logic fit_take;
        logic fit_dec;
        logic shift_rd;
        logic shift_wr;
        logic commit;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic item_full;
        logic size_known;
        logic scan_last;
        logic found;
        logic fit_empty;
        logic fit_hit;
        logic fit_pos_zero;
        logic shift_more;
        logic out_free;
    } dp_status_t;

endpackage

[hw/rtl/ibra_ctrl.sv]
// Controller state machine sequencing release scans, first-fit search and commit.
module ibra_ctrl
    import ibra_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t sts,
    output ctl_cmd_t   cmd,
    output ctl_state_t state
);

    ctl_state_t state_reg, state_next;

    assign state = state_reg;

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.item_full || !sts.size_known) state_next = ST_DONE;
                else state_next = ST_REL_SCAN;
            end
            ST_REL_SCAN: begin
                if (sts.scan_last) state_next = ST_REL_DRAIN;
            end
            ST_REL_DRAIN:  state_next = ST_REL_DECIDE;
            ST_REL_DECIDE: begin
                if (sts.found) state_next = ST_REL_SCAN;
                else state_next = ST_FIT_INIT;
            end
            ST_FIT_INIT: begin
                if (sts.fit_empty) state_next = ST_COMMIT;
                else state_next = ST_FIT_RD;
            end
            ST_FIT_RD: state_next = ST_FIT_CMP;
            ST_FIT_CMP: begin
                if (sts.fit_hit) state_next = ST_SHIFT_CHK;
                else if (sts.fit_pos_zero) state_next = ST_COMMIT;
                else state_next = ST_FIT_RD;
            end
            ST_SHIFT_CHK: begin
                if (sts.shift_more) state_next = ST_SHIFT_RD;
                else state_next = ST_COMMIT;
            end
            ST_SHIFT_RD: state_next = ST_SHIFT_WR;
            ST_SHIFT_WR: state_next = ST_SHIFT_CHK;
            ST_COMMIT:   state_next = ST_DONE;
            ST_DONE: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_CHECK: begin
                if (sts.item_full) cmd.set_ovf = 1'b1;
                else if (!sts.size_known) cmd.set_unknown = 1'b1;
                else cmd.scan_init = 1'b1;
            end
            ST_REL_SCAN:   cmd.scan_step = 1'b1;
            ST_REL_DRAIN:  cmd = '0;
            ST_REL_DECIDE: begin
                cmd.rel_push  = sts.found;
                cmd.scan_init = sts.found;
            end
            ST_FIT_INIT:   cmd.fit_init = 1'b1;
            ST_FIT_RD:     cmd.fit_rd = 1'b1;
            ST_FIT_CMP: begin
                cmd.fit_take = sts.fit_hit;
                cmd.fit_dec  = !sts.fit_hit && !sts.fit_pos_zero;
            end
            ST_SHIFT_CHK:  cmd = '0;
            ST_SHIFT_RD:   cmd.shift_rd = 1'b1;
            ST_SHIFT_WR:   cmd.shift_wr = 1'b1;
            ST_COMMIT:     cmd.commit = 1'b1;
            ST_DONE:       cmd.out_load = sts.out_free;
            default:       cmd = '0;
        endcase
    end

endmodule

[hw/rtl/ibra_dpath.sv]
// Datapath: item registers, live table, free list and result register.
module ibra_dpath
    import ibra_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  in_item_t   s_data,
    input  ctl_cmd_t   cmd,
    output dp_status_t sts,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    live_row_t live_mem [MAX_BUFFERS];
    free_row_t free_mem [MAX_BUFFERS];

    in_item_t           item_reg;
    logic [CNT_W-1:0]   item_idx_reg;
    logic [CNT_W-1:0]   free_cnt_reg;
    logic [MAX_BUFFERS-1:0] valid_reg;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic               cmp_en_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    live_row_t          live_rd_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    live_row_t          best_reg;
    logic [IDX_W-1:0]   fit_pos_reg;
    free_row_t          free_rd_reg;
    free_row_t          own_reg;
    logic               reused_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;
    out_item_t          res_reg;

    time_t              start_t;
    logic [IDX_W-1:0]   self_idx;
    logic [IDX_W-1:0]   free_raddr;
    logic [CNT_W-1:0]   shift_next;
    logic               better;

    assign start_t    = item_reg.start_time[TIME_BITS-1:0];
    assign self_idx   = item_idx_reg[IDX_W-1:0];
    assign free_raddr = cmd.shift_rd ? fit_pos_reg + 1'b1 : fit_pos_reg;
    assign shift_next = {1'b0, fit_pos_reg} + 1'b1;
    assign better     = cmp_en_reg && valid_reg[cmp_idx_reg]
                        && (live_rd_reg.end_t < start_t)
                        && (!found_reg || (live_rd_reg.end_t < best_reg.end_t));

    // Report status
    always_comb begin
        sts.item_full    = (item_idx_reg >= CNT_W'(MAX_BUFFERS));
        sts.size_known   = item_reg.size_known;
        sts.scan_last    = (scan_idx_reg == IDX_W'(MAX_BUFFERS - 1));
        sts.found        = found_reg;
        sts.fit_empty    = item_reg.is_external || (free_cnt_reg == '0);
        sts.fit_hit      = (free_rd_reg.size >= item_reg.buffer_size);
        sts.fit_pos_zero = (fit_pos_reg == '0);
        sts.shift_more   = (shift_next < free_cnt_reg);
        sts.out_free     = !m_valid_reg || m_ready;
    end

    // Control state: counters, valid bits, search tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_idx_reg <= '0;
            free_cnt_reg <= '0;
            valid_reg    <= '0;
            cmp_en_reg   <= 1'b0;
            found_reg    <= 1'b0;
            scan_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            cmp_en_reg <= cmd.scan_step;
            if (cmd.load && s_data.first_of_set) begin
                item_idx_reg <= '0;
                free_cnt_reg <= '0;
                valid_reg    <= '0;
            end
            if (cmd.set_unknown) item_idx_reg <= item_idx_reg + 1'b1;
            if (cmd.scan_init) begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end else if (better) begin
                found_reg <= 1'b1;
            end
            if (cmd.scan_step) scan_idx_reg <= scan_idx_reg + 1'b1;
            if (cmd.rel_push) begin
                valid_reg[best_idx_reg] <= 1'b0;
                if (free_cnt_reg < CNT_W'(MAX_BUFFERS)) free_cnt_reg <= free_cnt_reg + 1'b1;
            end
            if (cmd.commit) begin
                valid_reg[self_idx] <= 1'b1;
                item_idx_reg        <= item_idx_reg + 1'b1;
                if (reused_reg) free_cnt_reg <= free_cnt_reg - 1'b1;
            end
            if (cmd.out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) item_reg <= s_data;
        cmp_idx_reg <= scan_idx_reg;
        if (better) begin
            best_idx_reg <= cmp_idx_reg;
            best_reg     <= live_rd_reg;
        end
        if (cmd.set_ovf) res_reg <= '{memory_owner: '0, reused: 1'b0, overflow: 1'b1};
        if (cmd.set_unknown) begin
            res_reg <= '{memory_owner: item_idx_reg[OWNER_W-1:0], reused: 1'b0,
                         overflow: 1'b0};
        end
        if (cmd.fit_init) begin
            own_reg    <= '{owner: item_idx_reg[OWNER_W-1:0], size: item_reg.buffer_size};
            reused_reg <= 1'b0;
            fit_pos_reg <= IDX_W'(free_cnt_reg - 1'b1);
        end
        if (cmd.fit_dec) fit_pos_reg <= fit_pos_reg - 1'b1;
        if (cmd.fit_take) begin
            own_reg    <= free_rd_reg;
            reused_reg <= 1'b1;
        end
        if (cmd.shift_wr) fit_pos_reg <= fit_pos_reg + 1'b1;
        if (cmd.commit) begin
            res_reg <= '{memory_owner: own_reg.owner, reused: reused_reg, overflow: 1'b0};
        end
        if (cmd.out_load) m_data_reg <= res_reg;
    end

    // Live table: write on commit, read one row per scan step
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            live_mem[self_idx] <= '{end_t: item_reg.end_time[TIME_BITS-1:0],
                                    owner: own_reg.owner, size: own_reg.size};
        end
        live_rd_reg <= live_mem[scan_idx_reg];
    end

    // Free list: push released rows, compact after a take
    always_ff @(posedge aclk) begin
        if (cmd.rel_push && (free_cnt_reg < CNT_W'(MAX_BUFFERS))) begin
            free_mem[free_cnt_reg[IDX_W-1:0]] <= '{owner: best_reg.owner, size: best_reg.size};
        end else if (cmd.shift_wr) begin
            free_mem[fit_pos_reg] <= free_rd_reg;
        end
        if (cmd.fit_rd || cmd.shift_rd) free_rd_reg <= free_mem[free_raddr];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hw/rtl/interval_buffer_reuse_allocator.sv]
// Top level of the interval buffer reuse allocator.
//
// Buffer descriptors enter on the s_ channel (valid/ready), one transaction
// per buffer, already sorted by start time. Each gets one result transaction
// on the m_ channel: the owner index, a reuse flag and an overflow flag.
// One buffer is handled at a time; s_ready is high only in the idle state.
// An overflowed or unknown-size buffer goes from the check straight to the
// result. A tracked buffer runs one release scan per mapping it releases
// plus a final scan that finds none (each scan is one 64-entry pass over
// the live table memory), then, unless it is external, probes free entries
// from the head of the free list for a first fit and, when one is taken,
// shifts the entries above it down in the free list memory before commit.
// The result sits in an output register; the next buffer is accepted while
// it waits, and a new result is held back until the receiver takes the old,
// which adds the stall cycles to that buffer.
// Synchronous active-low reset clears the valid bits and counters at once;
// first_of_set does the same before its buffer.
module interval_buffer_reuse_allocator
    import ibra_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    ctl_cmd_t   cmd;
    dp_status_t sts;
    ctl_state_t state;

    ibra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd),
        .state   (state)
    );

    ibra_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A release only happens after a scan found a candidate
    a_push_found: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rel_push |-> sts.found)
        else $error("release without candidate");

    // A new result never overwrites one still waiting
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result overwritten");

    // An accepted transaction makes the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!s_ready && state == ST_CHECK))
        else $error("accept did not start work");

endmodule

[sim/tb_interval_buffer_reuse_allocator.sv]
// Self-checking testbench for the interval buffer reuse allocator.
`timescale 1ns / 100ps

module tb_interval_buffer_reuse_allocator;
    import ibra_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    interval_buffer_reuse_allocator DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Allocator state as the predictor sees it
    logic              pr_live_valid [MAX_BUFFERS];
    logic [15:0]       pr_live_end   [MAX_BUFFERS];
    logic [OWNER_W-1:0] pr_live_owner [MAX_BUFFERS];
    logic [SIZE_W-1:0] pr_live_size  [MAX_BUFFERS];
    logic [OWNER_W-1:0] pr_free_owner [MAX_BUFFERS];
    logic [SIZE_W-1:0] pr_free_size  [MAX_BUFFERS];
    int                pr_free_count;
    int                pr_item_index;

    in_item_t  pending_buffers[$];
    out_item_t expected_allocs[$];
    int        error_count;
    int        cycle_count;
    bit        stimulus_done;

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    task automatic clear_tables();
        for (int i = 0; i < MAX_BUFFERS; i++) pr_live_valid[i] = 1'b0;
        pr_free_count = 0;
        pr_item_index = 0;
    endtask

    // Compute the allocation for one buffer and advance the predictor state
    task automatic predict_alloc(input in_item_t b, output out_item_t r);
        int pick;
        int self_idx;
        logic [OWNER_W-1:0] owner;
        logic [SIZE_W-1:0]  owner_size;
        logic hit;
        if (b.first_of_set) clear_tables();
        r = '0;
        if (pr_item_index >= MAX_BUFFERS) begin
            r.overflow = 1'b1;
            return;
        end
        self_idx = pr_item_index;
        pr_item_index++;
        r.memory_owner = self_idx[OWNER_W-1:0];
        if (!b.size_known) return;
        // release expired mappings, earliest end first, ties by table order
        forever begin
            pick = -1;
            for (int i = 0; i < MAX_BUFFERS; i++)
                if (pr_live_valid[i] && pr_live_end[i] < b.start_time)
                    if (pick < 0 || pr_live_end[i] < pr_live_end[pick]) pick = i;
            if (pick < 0) break;
            pr_live_valid[pick] = 1'b0;
            if (pr_free_count < MAX_BUFFERS) begin
                pr_free_owner[pr_free_count] = pr_live_owner[pick];
                pr_free_size[pr_free_count]  = pr_live_size[pick];
                pr_free_count++;
            end
        end
        owner      = self_idx[OWNER_W-1:0];
        owner_size = b.buffer_size;
        hit        = 1'b0;
        // first fit from the head of the free list
        if (!b.is_external) begin
            for (int p = pr_free_count - 1; p >= 0 && !hit; p--) begin
                if (pr_free_size[p] >= b.buffer_size) begin
                    owner      = pr_free_owner[p];
                    owner_size = pr_free_size[p];
                    hit        = 1'b1;
                    for (int q = p; q + 1 < pr_free_count; q++) begin
                        pr_free_owner[q] = pr_free_owner[q + 1];
                        pr_free_size[q]  = pr_free_size[q + 1];
                    end
                    pr_free_count--;
                end
            end
        end
        pr_live_valid[self_idx] = 1'b1;
        pr_live_end[self_idx]   = b.end_time;
        pr_live_owner[self_idx] = owner;
        pr_live_size[self_idx]  = owner_size;
        r.memory_owner = owner;
        r.reused       = hit;
    endtask

    function automatic in_item_t make_buffer(bit first, int st, int en, logic [31:0] sz,
                                              bit known, bit ext);
        in_item_t b;
        b.first_of_set = first;
        b.start_time   = st[15:0];
        b.end_time     = en[15:0];
        b.buffer_size  = sz;
        b.size_known   = known;
        b.is_external  = ext;
        return b;
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            default: return 32'(64 * $urandom_range(1, 8));
        endcase
    endfunction

    // Append one descriptor to the stimulus queue
    task automatic queue_buffer(input in_item_t b);
        pending_buffers.insert(pending_buffers.size(), b);
    endtask

    // Mostly well-formed set of buffers with non-decreasing start times
    task automatic add_buffer_set(int count);
        int st;
        int en;
        st = ($urandom_range(0, 3) == 0) ? $urandom_range(40000, 65000) : $urandom_range(0, 50);
        for (int i = 0; i < count; i++) begin
            st = st + $urandom_range(0, 4);
            if (st > 65535) st = 65535;
            en = st + $urandom_range(0, 12);
            if (en > 65535) en = 65535;
            if ($urandom_range(0, 19) == 0) en = $urandom_range(0, 65535);
            queue_buffer(make_buffer(i == 0, st, en, pick_size(),
                                     $urandom_range(0, 9) != 0,
                                     $urandom_range(0, 6) == 0));
        end
    endtask

    initial begin
        int n;
        aresetn       = 1'b0;
        error_count   = 0;
        stimulus_done = 1'b0;
        clear_tables();

        // directed: extremes, unknown size, external, reuse, size zero
        queue_buffer(make_buffer(1, 0, 0, 32'd100, 1, 0));
        queue_buffer(make_buffer(0, 1, 5, 32'd50, 1, 0));
        queue_buffer(make_buffer(0, 2, 3, 32'd0, 0, 0));
        queue_buffer(make_buffer(0, 2, 65535, 32'hFFFF_FFFF, 1, 0));
        queue_buffer(make_buffer(0, 6, 8, 32'd40, 1, 0));
        queue_buffer(make_buffer(0, 7, 9, 32'd10, 1, 1));
        queue_buffer(make_buffer(0, 20, 30, 32'd0, 1, 0));
        queue_buffer(make_buffer(0, 20, 30, 32'd200, 1, 0));
        queue_buffer(make_buffer(0, 40, 41, 32'd1, 1, 0));
        queue_buffer(make_buffer(1, 65535, 65535, 32'hFFFF_FFFF, 1, 1));
        queue_buffer(make_buffer(0, 65535, 0, 32'd0, 1, 0));
        queue_buffer(make_buffer(1, 0, 65535, 32'd0, 0, 1));

        // random: mostly well-formed sets, some past capacity, some noise
        while (pending_buffers.size() < 540) begin
            case ($urandom_range(0, 19))
                0:       add_buffer_set($urandom_range(64, 70));
                1, 2:    queue_buffer(make_buffer($urandom_range(0, 1),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom(), $urandom_range(0, 1), $urandom_range(0, 1)));
                default: add_buffer_set($urandom_range(2, 30));
            endcase
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_buffers.size() == 0);
        @(posedge aclk);
        wait (!s_valid);
        wait (expected_allocs.size() == 0);
        repeat (300) @(posedge aclk);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard limit on the run
    initial begin
        #8000000;
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge aclk) begin
        cycle_count <= aresetn ? cycle_count + 1 : 0;
    end

    // Drive buffer descriptors; hold each until it is accepted
    always @(posedge aclk) begin
        out_item_t r;
        bit quiet;
        quiet = (cycle_count > 3000 && cycle_count < 15000);
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else if (!s_valid || s_ready) begin
            if (pending_buffers.size() != 0 && (quiet || $urandom_range(0, 99) >= 22)) begin
                s_data <= pending_buffers[0];
                predict_alloc(pending_buffers.pop_front(), r);
                expected_allocs.insert(expected_allocs.size(), r);
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Accept results with random backpressure and check them in order
    always @(posedge aclk) begin
        out_item_t e;
        bit quiet;
        quiet = (cycle_count > 3000 && cycle_count < 15000);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(0, 99) >= 22);
            if (m_valid && m_ready) begin
                if (expected_allocs.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $realtime, m_data);
                    error_count++;
                end else begin
                    e = expected_allocs.pop_front();
                    if (m_data.memory_owner !== e.memory_owner) begin
                        $display("%0t: memory_owner expected %0d actual %0d",
                                 $realtime, e.memory_owner, m_data.memory_owner);
                        error_count++;
                    end
                    if (m_data.reused !== e.reused) begin
                        $display("%0t: reused expected %0b actual %0b",
                                 $realtime, e.reused, m_data.reused);
                        error_count++;
                    end
                    if (m_data.overflow !== e.overflow) begin
                        $display("%0t: overflow expected %0b actual %0b",
                                 $realtime, e.overflow, m_data.overflow);
                        error_count++;
                    end
                end
            end
        end
    end

endmodule

[interval_buffer_reuse_allocator.f]
hw/rtl/ibra_pkg.sv
hw/rtl/ibra_ctrl.sv
hw/rtl/ibra_dpath.sv
hw/rtl/interval_buffer_reuse_allocator.sv
sim/tb_interval_buffer_reuse_allocator.sv
